/* design/url_filename_sanitizer_assert.svh */
// Assertion macros for the URL file-name sanitizer checkers
`ifndef URL_FILENAME_SANITIZER_ASSERT_SVH
`define URL_FILENAME_SANITIZER_ASSERT_SVH

// check consequent in the same cycle as the antecedent
`define UFS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ufs assertion failed");

// check consequent in the cycle after the antecedent
`define UFS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ufs assertion failed");

`endif

/* design/ufs_pkg.sv */
// Types, constants and character helpers of the URL file-name sanitizer
package ufs_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CAND_DEPTH  = 3;
    localparam int unsigned DIGIT_DEPTH = 10;
    localparam int unsigned PREFIX_LEN  = 5;
    localparam int unsigned DIV10_SHIFT = 35;

    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd100;
    localparam logic [BYTE_W-1:0] CH_PCT        = 8'h25;
    localparam logic [BYTE_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_US         = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [TIME_W-1:0] DIV10_RECIP   = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_HEX1
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_DIV,
        S_REM,
        S_PFX,
        S_DIG,
        S_FLUSH
    } t_state;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic logic is_name_char(input logic [BYTE_W-1:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2E, 8'h5F, 8'h2D};
    endfunction

    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0: c = 8'h66;
            3'd1: c = 8'h69;
            3'd2: c = 8'h6C;
            3'd3: c = 8'h65;
            default: c = CH_US;
        endcase
        return c;
    endfunction

endpackage

/* design/ufs_if.sv */
// Valid/ready channel interfaces for sanitizer input and output transfers
interface ufs_in_if;
    logic        valid;
    logic        ready;
    logic        byte_present;
    logic [7:0]  raw_byte;
    logic        is_last;
    logic [31:0] time_ms;

    modport source (output valid, output byte_present, output raw_byte, output is_last,
                    output time_ms, input ready);
    modport sink   (input valid, input byte_present, input raw_byte, input is_last,
                    input time_ms, output ready);
endinterface

interface ufs_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       end_of_name;

    modport source (output valid, output byte_valid, output out_byte, output end_of_name,
                    input ready);
    modport sink   (input valid, input byte_valid, input out_byte, input end_of_name,
                    output ready);
endinterface

/* design/url_filename_sanitizer.sv */
// Top level of the URL file-name sanitizer
//
// Usage: one raw byte of a percent-encoded name per input transfer on i_in
// (byte_present, raw_byte, is_last, time_ms). Sanitized bytes leave one per
// output transfer on o_out; end_of_name flags the final result of a name.
// A last item that yields no byte, in a name that already has bytes, gives
// one result with byte_valid low. max_name_length is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while idle, and the
// block does not enforce this. Flow: an item is decoded into up to three
// candidate bytes, and the shared filter/emit path handles one candidate
// per cycle unless the output stalls. An empty name adds the decimal
// fallback: the divide-by-ten unit yields the digits one by one, then the
// prefix and the digits go out on the emit path.
// i_in.ready is high only between items. The newest byte waits in a hold
// stage until the next one or the end of the item decides its end flag.
// Reset (synchronous, active low) clears the decoder, length counter and the
// output register and sets max_name_length to 100. A stalled receiver holds
// the output register and stops the sequencer at its next output.
module url_filename_sanitizer import ufs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    ufs_in_if.sink            i_in,
    ufs_out_if.source         o_out
);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_held, n_held;
    logic              r_prev_us, n_prev_us;
    logic [BYTE_W-1:0] r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_max_len;
    logic              r_last, n_last;
    logic [TIME_W-1:0] r_time, n_time;
    logic [BYTE_W-1:0] r_cand [0:CAND_DEPTH-1];
    logic [BYTE_W-1:0] n_cand [0:CAND_DEPTH-1];
    logic [1:0]        r_nc, n_nc;
    logic [1:0]        r_ci, n_ci;
    logic [3:0]        r_k, n_k;
    logic [2:0]        r_pi, n_pi;
    logic              r_pend_v, n_pend_v;
    logic [BYTE_W-1:0] r_pend_b, n_pend_b;
    logic              r_ov, n_ov;
    logic              r_obv, n_obv;
    logic [BYTE_W-1:0] r_ob, n_ob;
    logic              r_oend, n_oend;
    logic [3:0]        r_digits [0:DIGIT_DEPTH-1];

    logic [BYTE_W-1:0] w_cand [0:CAND_DEPTH-1];
    logic [1:0]        w_nc;
    t_phase            w_phase;
    logic [BYTE_W-1:0] w_held;
    logic              w_feed;

    logic              w_accept;
    logic              w_out_free;
    logic              w_cand_done;
    logic [BYTE_W-1:0] w_cur;
    logic [BYTE_W-1:0] w_fc;
    logic              w_is_us;
    logic              w_produce;
    logic              w_emit_go;
    logic              w_gen_go;
    logic [TIME_W-1:0] w_quot;
    logic [3:0]        w_digit;
    logic [3:0]        w_dig_rd;

    ufs_div10 u_div10 (
        .i_clk   (i_clk),
        .i_load  (r_state == S_DIV),
        .i_value (r_time),
        .o_quot  (w_quot),
        .o_digit (w_digit)
    );

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_cand_done = (r_ci == r_nc);
    assign w_cur       = r_cand[r_ci];
    assign w_fc        = is_name_char(w_cur) ? w_cur : CH_US;
    assign w_is_us     = (w_fc == CH_US);
    assign w_produce   = !(w_is_us && r_prev_us) && (r_cnt < r_max_len);
    assign w_emit_go   = !w_produce || !r_pend_v || w_out_free;
    assign w_gen_go    = !r_pend_v || w_out_free;
    assign w_dig_rd    = r_digits[r_k - 4'd1];

    always_comb begin
        w_cand  = '{default: '0};
        w_nc    = 2'd0;
        w_phase = r_phase;
        w_held  = r_held;
        w_feed  = 1'b0;
        if (i_in.byte_present) begin
            case (r_phase)
                PH_PCT: begin
                    if (is_hex(i_in.raw_byte)) begin
                        w_held  = i_in.raw_byte;
                        w_phase = PH_HEX1;
                    end else begin
                        w_cand[w_nc] = CH_PCT;
                        w_nc         = w_nc + 2'd1;
                        w_feed       = 1'b1;
                    end
                end
                PH_HEX1: begin
                    if (is_hex(i_in.raw_byte)) begin
                        w_cand[w_nc] = {hex_value(r_held), hex_value(i_in.raw_byte)};
                        w_nc         = w_nc + 2'd1;
                        w_phase      = PH_IDLE;
                    end else begin
                        w_cand[w_nc] = CH_PCT;
                        w_nc         = w_nc + 2'd1;
                        w_cand[w_nc] = r_held;
                        w_nc         = w_nc + 2'd1;
                        w_feed       = 1'b1;
                    end
                end
                default: begin
                    w_feed = 1'b1;
                end
            endcase
        end
        if (w_feed) begin
            w_phase = PH_IDLE;
            if (i_in.raw_byte == CH_PCT) begin
                w_phase = PH_PCT;
            end else if (i_in.raw_byte == CH_PLUS) begin
                w_cand[w_nc] = CH_SPACE;
                w_nc         = w_nc + 2'd1;
            end else begin
                w_cand[w_nc] = i_in.raw_byte;
                w_nc         = w_nc + 2'd1;
            end
        end
        if (i_in.is_last) begin
            case (w_phase)
                PH_PCT: begin
                    w_cand[w_nc] = CH_PCT;
                    w_nc         = w_nc + 2'd1;
                end
                PH_HEX1: begin
                    w_cand[w_nc] = CH_PCT;
                    w_nc         = w_nc + 2'd1;
                    w_cand[w_nc] = w_held;
                    w_nc         = w_nc + 2'd1;
                end
                default: begin
                end
            endcase
            w_phase = PH_IDLE;
            w_held  = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_cand_done) begin
                    n_state = (r_last && r_cnt == '0) ? S_DIV : S_FLUSH;
                end
            end
            S_DIV: begin
                n_state = S_REM;
            end
            S_REM: begin
                n_state = (w_quot == '0) ? S_PFX : S_DIV;
            end
            S_PFX: begin
                if (w_gen_go && r_pi == 3'(PREFIX_LEN - 1)) begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (w_gen_go && r_k == 4'd1) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_out_free || (!r_last && !r_pend_v)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        n_prev_us = r_prev_us;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_time    = r_time;
        n_cand    = r_cand;
        n_nc      = r_nc;
        n_ci      = r_ci;
        n_k       = r_k;
        n_pi      = r_pi;
        n_pend_v  = r_pend_v;
        n_pend_b  = r_pend_b;
        n_ov      = r_ov && !o_out.ready;
        n_obv     = r_obv;
        n_ob      = r_ob;
        n_oend    = r_oend;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cand  = w_cand;
                    n_nc    = w_nc;
                    n_ci    = 2'd0;
                    n_phase = w_phase;
                    n_held  = w_held;
                    n_last  = i_in.is_last;
                    n_time  = i_in.time_ms;
                    n_k     = 4'd0;
                    n_pi    = 3'd0;
                end
            end
            S_EMIT: begin
                if (!w_cand_done && w_emit_go) begin
                    n_ci = r_ci + 2'd1;
                    if (w_produce) begin
                        n_cnt     = r_cnt + 8'd1;
                        n_prev_us = w_is_us;
                        if (r_pend_v) begin
                            n_ov   = 1'b1;
                            n_obv  = 1'b1;
                            n_ob   = r_pend_b;
                            n_oend = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend_b = w_fc;
                    end
                end
            end
            S_REM: begin
                n_k    = r_k + 4'd1;
                n_time = w_quot;
            end
            S_PFX, S_DIG: begin
                if (w_gen_go) begin
                    if (r_pend_v) begin
                        n_ov   = 1'b1;
                        n_obv  = 1'b1;
                        n_ob   = r_pend_b;
                        n_oend = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    if (r_state == S_PFX) begin
                        n_pend_b = prefix_char(r_pi);
                        n_pi     = r_pi + 3'd1;
                    end else begin
                        n_pend_b = CH_ZERO + {4'd0, w_dig_rd};
                        n_k      = r_k - 4'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    if (r_pend_v) begin
                        n_ov   = 1'b1;
                        n_obv  = 1'b1;
                        n_ob   = r_pend_b;
                        n_oend = r_last;
                    end else if (r_last) begin
                        n_ov   = 1'b1;
                        n_obv  = 1'b0;
                        n_ob   = '0;
                        n_oend = 1'b1;
                    end
                    n_pend_v = 1'b0;
                    if (r_last) begin
                        n_cnt     = '0;
                        n_prev_us = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_REM) begin
            r_digits[r_k] <= w_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_held    <= '0;
            r_prev_us <= 1'b0;
            r_cnt     <= '0;
            r_max_len <= MAX_LEN_RESET;
            r_pend_v  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_prev_us <= n_prev_us;
            r_cnt     <= n_cnt;
            r_pend_v  <= n_pend_v;
            r_ov      <= n_ov;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_time   <= n_time;
        r_cand   <= n_cand;
        r_nc     <= n_nc;
        r_ci     <= n_ci;
        r_k      <= n_k;
        r_pi     <= n_pi;
        r_pend_b <= n_pend_b;
        r_obv    <= n_obv;
        r_ob     <= n_ob;
        r_oend   <= n_oend;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.byte_valid  = r_obv;
    assign o_out.out_byte    = r_ob;
    assign o_out.end_of_name = r_oend;

endmodule

/* design/ufs_div10.sv */
// Divide-by-ten unit: registered reciprocal quotient and decimal remainder
module ufs_div10 import ufs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [TIME_W-1:0] i_value,
    output logic [TIME_W-1:0] o_quot,
    output logic [3:0]        o_digit
);

    logic [2*TIME_W-1:0] w_prod;
    logic [TIME_W-1:0]   r_val;
    logic [TIME_W-1:0]   r_quot;
    logic [TIME_W-1:0]   w_rem;

    assign w_prod = {{TIME_W{1'b0}}, i_value} * {{TIME_W{1'b0}}, DIV10_RECIP};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val  <= i_value;
            r_quot <= TIME_W'(w_prod[2*TIME_W-1:DIV10_SHIFT]);
        end
    end

    assign w_rem   = r_val - ((r_quot << 3) + (r_quot << 1));
    assign o_quot  = r_quot;
    assign o_digit = w_rem[3:0];

endmodule

/* design/ufs_chk.sv */
// Port-level checker for the URL file-name sanitizer and its bind
module ufs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_byte_valid,
    input logic [7:0] i_out_byte,
    input logic       i_out_end
);

`include "url_filename_sanitizer_assert.svh"

    `UFS_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && i_in_ready, !i_in_ready)

    `UFS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_end) && $stable(i_out_byte_valid))

    `UFS_ASSERT_SAME(a_empty_marks_end, i_out_valid && !i_out_byte_valid, i_out_end && (i_out_byte == 8'h00))

endmodule

bind url_filename_sanitizer ufs_chk u_ufs_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte_valid (o_out.byte_valid),
    .i_out_byte       (o_out.out_byte),
    .i_out_end        (o_out.end_of_name)
);
